// ===== sv/u8u16bh_pkg.sv =====
package u8u16bh_pkg;

   localparam int unsigned MAX_CODE_POINTS = 15;
   localparam logic [4:0]  CP_LIMIT        = 5'(MAX_CODE_POINTS);
   localparam logic [4:0]  UNIT_CAP        = 5'd30;
   localparam logic [9:0]  HASH_SEED       = 10'd261;
   localparam logic [20:0] SUPP_BASE       = 21'h10000;
   localparam logic [15:0] HI_SURR_BASE    = 16'hd800;
   localparam logic [15:0] LO_SURR_BASE    = 16'hdc00;

   typedef enum logic [1:0] {
      KIND_UNIT = 2'd0,
      KIND_OK   = 2'd1,
      KIND_ERR  = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] unit_a;
      logic [15:0] unit_b;
      logic [9:0]  hash;
      logic [4:0]  count_a;
      logic        two;
   } entry_type;

   function automatic logic [9:0] hash_step(input logic [9:0] h, input logic [15:0] unit);
      hash_step = {h[4:0], 5'd0} + h + unit[9:0];
   endfunction

endpackage

// ===== sv/utf8_to_utf16_with_bucket_hash.sv =====
// Channel | Ports                                      | Direction
// req     | req_valid, req_stall, req_in_byte          | in
// rsp     | rsp_valid, rsp_stall, rsp_kind,            | out
//         | rsp_code_unit, rsp_bucket_hash,            |
//         | rsp_unit_count, rsp_last_of_run            |
//
// One byte is taken per cycle unless req_stall is high; decode and hash are finished
// in the cycle of the transfer and the results land in a two-entry output queue.
// A surrogate pair occupies the result port for two transfers, high unit first.
// req_stall rises while the second queue entry is occupied.
// Synchronous reset clears the decoder state, the hash to its seed and the queue.
module utf8_to_utf16_with_bucket_hash (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [15:0] rsp_code_unit,
   output logic [9:0]  rsp_bucket_hash,
   output logic [4:0]  rsp_unit_count,
   output logic        rsp_last_of_run
);

   logic [20:0] partial_ff, partial_in;
   logic [1:0]  expect_ff, expect_in;
   logic [4:0]  cp_done_ff, cp_done_in;
   logic [4:0]  units_ff, units_in;
   logic [9:0]  hash_ff, hash_in;
   logic        err_ff, err_in;

   u8u16bh_pkg::entry_type out_ff, out_in, skid_ff, skid_in, new_entry;
   logic out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;
   logic phase_ff, phase_in;

   logic        accept, emit, finish, pop_done;
   logic [20:0] shifted, cp, off;
   logic [15:0] hi_unit, lo_unit;
   logic [9:0]  hash_hi;
   logic        bad;

   assign accept   = req_valid && !req_stall;
   assign req_stall = skid_valid_ff;
   assign pop_done = out_valid_ff && !rsp_stall && (!out_ff.two || phase_ff);

   always_comb begin
      shifted = {partial_ff[14:0], req_in_byte[5:0]};
      off     = cp - u8u16bh_pkg::SUPP_BASE;
      hi_unit = u8u16bh_pkg::HI_SURR_BASE + {5'd0, off[20:10]};
      lo_unit = u8u16bh_pkg::LO_SURR_BASE + {6'd0, off[9:0]};
      hash_hi = u8u16bh_pkg::hash_step(hash_ff, hi_unit);
      bad     = err_ff || (expect_ff != 2'd0);
   end

   always_comb begin
      partial_in = partial_ff;
      expect_in  = expect_ff;
      cp_done_in = cp_done_ff;
      units_in   = units_ff;
      hash_in    = hash_ff;
      err_in     = err_ff;
      emit       = 1'b0;
      finish     = 1'b0;
      cp         = '0;
      new_entry  = '0;
      if (accept) begin
         if (req_in_byte == 8'd0) begin
            emit              = 1'b1;
            new_entry.kind    = bad ? u8u16bh_pkg::KIND_ERR : u8u16bh_pkg::KIND_OK;
            new_entry.hash    = bad ? 10'd0 : hash_ff;
            new_entry.count_a = units_ff;
            partial_in        = '0;
            expect_in         = 2'd0;
            cp_done_in        = 5'd0;
            units_in          = 5'd0;
            hash_in           = u8u16bh_pkg::HASH_SEED;
            err_in            = 1'b0;
         end else if (!err_ff) begin
            if (expect_ff == 2'd0) begin
               if (!req_in_byte[7]) begin
                  cp     = {13'd0, req_in_byte};
                  finish = 1'b1;
               end else if (req_in_byte[7:5] == 3'b110) begin
                  partial_in = {16'd0, req_in_byte[4:0]};
                  expect_in  = 2'd1;
               end else if (req_in_byte[7:4] == 4'b1110) begin
                  partial_in = {17'd0, req_in_byte[3:0]};
                  expect_in  = 2'd2;
               end else if (req_in_byte[7:3] == 5'b11110) begin
                  partial_in = {18'd0, req_in_byte[2:0]};
                  expect_in  = 2'd3;
               end else begin
                  err_in     = 1'b1;
                  partial_in = '0;
                  expect_in  = 2'd0;
               end
            end else if (req_in_byte[7:6] != 2'b10) begin
               err_in     = 1'b1;
               partial_in = '0;
               expect_in  = 2'd0;
            end else begin
               expect_in = expect_ff - 2'd1;
               if (expect_ff == 2'd1) begin
                  cp         = shifted;
                  partial_in = '0;
                  finish     = 1'b1;
               end else begin
                  partial_in = shifted;
               end
            end
            if (finish) begin
               if (cp_done_ff >= u8u16bh_pkg::CP_LIMIT) begin
                  err_in     = 1'b1;
                  partial_in = '0;
                  expect_in  = 2'd0;
               end else begin
                  cp_done_in = cp_done_ff + 5'd1;
                  if (units_ff < u8u16bh_pkg::UNIT_CAP) begin
                     emit           = 1'b1;
                     new_entry.kind = u8u16bh_pkg::KIND_UNIT;
                     if (cp[20:16] == 5'd0) begin
                        new_entry.unit_a  = cp[15:0];
                        new_entry.count_a = units_ff + 5'd1;
                        hash_in  = u8u16bh_pkg::hash_step(hash_ff, cp[15:0]);
                        units_in = units_ff + 5'd1;
                     end else begin
                        new_entry.unit_a  = hi_unit;
                        new_entry.unit_b  = lo_unit;
                        new_entry.two     = 1'b1;
                        new_entry.count_a = units_ff + 5'd1;
                        hash_in  = u8u16bh_pkg::hash_step(hash_hi, lo_unit);
                        units_in = units_ff + 5'd2;
                     end
                  end
               end
            end
         end
      end
   end

   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      phase_in      = phase_ff;
      if (out_valid_ff && !rsp_stall && !pop_done) begin
         phase_in = 1'b1;
      end
      if (!out_valid_ff || pop_done) begin
         phase_in = 1'b0;
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else if (emit) begin
            out_in       = new_entry;
            out_valid_in = 1'b1;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (emit) begin
         skid_in       = new_entry;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff    <= '0;
         expect_ff     <= 2'd0;
         cp_done_ff    <= 5'd0;
         units_ff      <= 5'd0;
         hash_ff       <= u8u16bh_pkg::HASH_SEED;
         err_ff        <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
         phase_ff      <= 1'b0;
      end else begin
         partial_ff    <= partial_in;
         expect_ff     <= expect_in;
         cp_done_ff    <= cp_done_in;
         units_ff      <= units_in;
         hash_ff       <= hash_in;
         err_ff        <= err_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
         phase_ff      <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_kind        = out_ff.kind;
   assign rsp_code_unit   = phase_ff ? out_ff.unit_b : out_ff.unit_a;
   assign rsp_bucket_hash = out_ff.hash;
   assign rsp_unit_count  = phase_ff ? out_ff.count_a + 5'd1 : out_ff.count_a;
   assign rsp_last_of_run = phase_ff || !out_ff.two;

`ifndef NO_ASSERTIONS
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held while output register empty");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != u8u16bh_pkg::KIND_UNIT) |-> rsp_last_of_run)
      else $error("string end result not marked last");

   a_pair_high_first: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_run |-> rsp_code_unit[15:11] == 5'b11011)
      else $error("first of a pair is not a high surrogate");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      accept && (req_in_byte == 8'd0) |=> (units_ff == 5'd0) && !err_ff
         && (hash_ff == u8u16bh_pkg::HASH_SEED))
      else $error("string state not cleared after terminator");
`endif

endmodule

// ===== tb/tb_utf8_to_utf16_with_bucket_hash.sv =====
`timescale 1ns / 100ps

module tb_utf8_to_utf16_with_bucket_hash;

   typedef struct packed {
      u8u16bh_pkg::kind_type kind;
      logic [15:0]           code_unit;
      logic [9:0]            hash;
      logic [4:0]            count;
      logic                  last_flag;
   } utf16_out_type;

   typedef struct packed {
      logic [7:0]    b;
      logic          fixed;
      utf16_out_type want;
   } step_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_in_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_kind;
   logic [15:0] rsp_code_unit;
   logic [9:0]  rsp_bucket_hash;
   logic [4:0]  rsp_unit_count;
   logic        rsp_last_of_run;

   utf16_out_type due_utf16 [$];
   step_row_type  opening_rows [24];

   logic [20:0] pend_cp;
   logic [1:0]  cont_left;
   logic [4:0]  cp_total;
   logic [4:0]  unit_total;
   logic [9:0]  unit_hash;
   logic        string_broken;

   int mismatches = 0;
   int live_bytes = 0;
   int send_gap_pct = 0;
   int recv_stall_pct = 0;
   int phase_gap_pct [4] = '{0, 64, 0, 21};
   int phase_stall_pct [4] = '{0, 0, 64, 21};

   utf8_to_utf16_with_bucket_hash dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_code_unit   (rsp_code_unit),
      .rsp_bucket_hash (rsp_bucket_hash),
      .rsp_unit_count  (rsp_unit_count),
      .rsp_last_of_run (rsp_last_of_run)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic void restart_string();
      pend_cp = '0;
      cont_left = '0;
      cp_total = '0;
      unit_total = '0;
      unit_hash = u8u16bh_pkg::HASH_SEED;
      string_broken = 1'b0;
   endfunction

   function automatic void mark_broken();
      string_broken = 1'b1;
      cont_left = '0;
      pend_cp = '0;
   endfunction

   function automatic void fold_unit(input logic [15:0] cu, input logic last_flag);
      utf16_out_type res;
      unit_hash = 10'((32'(unit_hash) * 33) + 32'(cu));
      unit_total = unit_total + 5'd1;
      res = '{u8u16bh_pkg::KIND_UNIT, cu, 10'h0, unit_total, last_flag};
      due_utf16.push_back(res);
   endfunction

   // returns 0 for a byte swallowed after an error
   function automatic bit decode_byte(input logic [7:0] b);
      utf16_out_type res;
      logic [20:0]   cp;
      logic [20:0]   off;
      if (b == 8'h00) begin
         if (string_broken || cont_left != 2'd0)
            res = '{u8u16bh_pkg::KIND_ERR, 16'h0, 10'h0, unit_total, 1'b1};
         else
            res = '{u8u16bh_pkg::KIND_OK, 16'h0, unit_hash, unit_total, 1'b1};
         due_utf16.push_back(res);
         restart_string();
         return 1'b1;
      end
      if (string_broken)
         return 1'b0;
      if (cont_left == 2'd0) begin
         if (b < 8'h80) begin
            cp = {13'h0, b};
         end else if ((b & 8'he0) == 8'hc0) begin
            pend_cp = {16'h0, b[4:0]};
            cont_left = 2'd1;
            return 1'b1;
         end else if ((b & 8'hf0) == 8'he0) begin
            pend_cp = {17'h0, b[3:0]};
            cont_left = 2'd2;
            return 1'b1;
         end else if ((b & 8'hf8) == 8'hf0) begin
            pend_cp = {18'h0, b[2:0]};
            cont_left = 2'd3;
            return 1'b1;
         end else begin
            mark_broken();
            return 1'b1;
         end
      end else begin
         if ((b & 8'hc0) != 8'h80) begin
            mark_broken();
            return 1'b1;
         end
         pend_cp = {pend_cp[14:0], b[5:0]};
         cont_left = cont_left - 2'd1;
         if (cont_left != 2'd0)
            return 1'b1;
         cp = pend_cp;
         pend_cp = '0;
      end
      if (cp_total >= u8u16bh_pkg::CP_LIMIT) begin
         mark_broken();
         return 1'b1;
      end
      cp_total = cp_total + 5'd1;
      if (unit_total >= u8u16bh_pkg::UNIT_CAP)
         return 1'b1;
      if (cp < u8u16bh_pkg::SUPP_BASE) begin
         fold_unit(cp[15:0], 1'b1);
      end else begin
         off = cp - u8u16bh_pkg::SUPP_BASE;
         fold_unit(u8u16bh_pkg::HI_SURR_BASE + 16'(off >> 10), 1'b0);
         fold_unit(u8u16bh_pkg::LO_SURR_BASE + {6'h0, off[9:0]}, 1'b1);
      end
      return 1'b1;
   endfunction

   task automatic flag_mismatch(input string what, input int got, input int wanted);
      mismatches++;
      if (mismatches <= 50)
         $display("mismatch on %s: got %0h, wanted %0h at %0t", what, got, wanted, $time);
   endtask

   function automatic step_row_type row_free(input logic [7:0] b);
      row_free = '{b, 1'b0, '{u8u16bh_pkg::KIND_UNIT, 16'h0, 10'h0, 5'h0, 1'b0}};
   endfunction

   function automatic step_row_type row_fixed(input logic [7:0] b,
                                              input u8u16bh_pkg::kind_type k,
                                              input logic [15:0] cu, input logic [9:0] h,
                                              input logic [4:0] n);
      row_fixed = '{b, 1'b1, '{k, cu, h, n, 1'b1}};
   endfunction

   task automatic send_byte(input step_row_type r);
      int queued;
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= r.b;
      do @(posedge clock); while (req_stall);
      queued = due_utf16.size();
      if (decode_byte(r.b))
         live_bytes++;
      if (r.fixed) begin
         while (due_utf16.size() > queued)
            void'(due_utf16.pop_back());
         due_utf16.push_back(r.want);
      end
   endtask

   function automatic logic [7:0] bad_lead_byte();
      int pick;
      pick = $urandom_range(0, 71);
      return (pick < 64) ? 8'(8'h80 + pick) : 8'(8'hf8 + pick - 64);
   endfunction

   task automatic send_random_string();
      int         n_cp;
      int         form;
      int         spoil_at;
      int         spoil_how;
      int         pick;
      int         keep;
      logic [7:0] seq [$];
      if ($urandom_range(99) < 8) begin
         repeat ($urandom_range(1, 6))
            send_byte(row_free(8'($urandom_range(1, 255))));
         send_byte(row_free(8'h00));
         return;
      end
      n_cp = ($urandom_range(99) < 25) ? $urandom_range(13, 18) : $urandom_range(0, 8);
      spoil_at = ($urandom_range(99) < 18) ? $urandom_range(0, n_cp) : -1;
      spoil_how = $urandom_range(0, 2);
      for (int i = 0; i < n_cp; i++) begin
         form = $urandom_range(1, 4);
         seq.delete();
         case (form)
            1: seq.push_back(8'($urandom_range(1, 127)));
            2: seq.push_back(8'hc0 | 8'($urandom_range(0, 31)));
            3: seq.push_back(8'he0 | 8'($urandom_range(0, 15)));
            default: seq.push_back(8'hf0 | 8'($urandom_range(0, 7)));
         endcase
         repeat (form - 1)
            seq.push_back(8'h80 | 8'($urandom_range(0, 63)));
         if (i == spoil_at) begin
            if (form == 1 || spoil_how == 0) begin
               seq[0] = bad_lead_byte();
            end else if (spoil_how == 1) begin
               pick = $urandom_range(0, 190);
               seq[$urandom_range(1, form - 1)] =
                  (pick < 127) ? 8'(pick + 1) : 8'(8'hc0 + pick - 127);
            end else begin
               keep = $urandom_range(1, form - 1);
               for (int j = 0; j < keep; j++)
                  send_byte(row_free(seq[j]));
               send_byte(row_free(8'h00));
               return;
            end
         end
         foreach (seq[j])
            send_byte(row_free(seq[j]));
      end
      send_byte(row_free(8'h00));
   endtask

   always @(posedge clock)
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);

   always @(posedge clock) begin
      utf16_out_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_utf16.size() == 0) begin
            flag_mismatch("unexpected transfer, unit", int'(rsp_code_unit), 0);
         end else begin
            want = due_utf16.pop_front();
            if (rsp_kind != want.kind)
               flag_mismatch("kind", int'(rsp_kind), int'(want.kind));
            if (rsp_code_unit != want.code_unit)
               flag_mismatch("code_unit", int'(rsp_code_unit), int'(want.code_unit));
            if (rsp_bucket_hash != want.hash)
               flag_mismatch("bucket_hash", int'(rsp_bucket_hash), int'(want.hash));
            if (rsp_unit_count != want.count)
               flag_mismatch("unit_count", int'(rsp_unit_count), int'(want.count));
            if (rsp_last_of_run != want.last_flag)
               flag_mismatch("last_of_run", int'(rsp_last_of_run), int'(want.last_flag));
         end
      end
   end

   initial begin
      int live_target;
      reset = 1'b1;
      req_valid = 1'b0;
      req_in_byte = 8'h00;
      rsp_stall = 1'b0;
      restart_string();
      opening_rows = '{
         row_fixed(8'h00, u8u16bh_pkg::KIND_OK, 16'h0, 10'd261, 5'd0),
         row_fixed(8'h7f, u8u16bh_pkg::KIND_UNIT, 16'h007f, 10'h0, 5'd1),
         row_free(8'h00),
         row_free(8'hc0), row_free(8'h80),
         row_free(8'hf4), row_free(8'h8f), row_free(8'hbf), row_free(8'hbf),
         row_free(8'hef), row_free(8'hbf), row_free(8'hbf),
         row_free(8'h00),
         row_free(8'h80), row_free(8'h41),
         row_fixed(8'h00, u8u16bh_pkg::KIND_ERR, 16'h0, 10'h0, 5'd0),
         row_free(8'hff),
         row_fixed(8'h00, u8u16bh_pkg::KIND_ERR, 16'h0, 10'h0, 5'd0),
         row_free(8'he2), row_free(8'h41),
         row_fixed(8'h00, u8u16bh_pkg::KIND_ERR, 16'h0, 10'h0, 5'd0),
         row_free(8'h41), row_free(8'hc3),
         row_fixed(8'h00, u8u16bh_pkg::KIND_ERR, 16'h0, 10'h0, 5'd1)
      };
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      foreach (opening_rows[i])
         send_byte(opening_rows[i]);
      for (int p = 0; p < 4; p++) begin
         send_gap_pct = phase_gap_pct[p];
         recv_stall_pct = phase_stall_pct[p];
         live_target = live_bytes + 95;
         while (live_bytes < live_target)
            send_random_string();
      end
      req_valid <= 1'b0;
      while (due_utf16.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
